>>> rtl/core/clfs_pkg.sv
package clfs_pkg;

    // Default width of the internal line counter
    localparam int LINE_COUNT_WIDTH_DEF = 16;

    // Width of the line number shown on the result channel
    localparam int LINE_NUMBER_W = 16;

    // Special characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Quoting state
    typedef enum logic [1:0] {
        QM_UNQUOTED = 2'd0,
        QM_QUOTED   = 2'd1,
        QM_PENDING  = 2'd2
    } quote_mode_t;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_line;
    } clfs_in_t;

    // Result transaction payload
    typedef struct packed {
        logic [7:0]               field_byte;
        logic                     byte_valid;
        logic                     end_of_field;
        logic                     end_of_record;
        logic                     format_error;
        logic [LINE_NUMBER_W-1:0] line_number;
    } clfs_out_t;

endpackage

>>> rtl/core/clfs_in_reg.sv
module clfs_in_reg
    import clfs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  clfs_in_t s_data,
    input  logic     out_free,
    output logic     advance,
    output clfs_in_t in_data
);

    logic     valid_reg;
    logic     valid_next;
    clfs_in_t data_reg;

    // Item moves on when the result stage has room
    assign advance = valid_reg && out_free;
    assign s_ready = !valid_reg || advance;
    assign in_data = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

>>> rtl/core/clfs_parser.sv
module clfs_parser
    import clfs_pkg::*;
#(
    parameter int LINE_COUNT_WIDTH = LINE_COUNT_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  clfs_in_t  in_data,
    output logic      res_valid,
    output clfs_out_t res_data
);

    quote_mode_t                 mode_reg;
    quote_mode_t                 mode_next;
    logic                        has_bytes_reg;
    logic                        has_bytes_next;
    logic [LINE_COUNT_WIDTH-1:0] line_cnt_reg;
    logic [LINE_COUNT_WIDTH-1:0] line_cnt_next;
    logic [LINE_COUNT_WIDTH-1:0] line_cnt_bumped;
    logic [31:0]                 line_cnt_ext;

    logic [7:0] b;
    logic       last;
    logic       cr_last;
    logic       plain;
    logic       emit;
    logic       sep;
    logic       err;
    logic [7:0] val;
    quote_mode_t mode_mid;

    assign b       = in_data.data_byte;
    assign last    = in_data.last_of_line;
    assign cr_last = last && (b == CH_CR);

    // Saturating line count, shown through its low bits
    assign line_cnt_bumped = (&line_cnt_reg) ? line_cnt_reg
                                             : line_cnt_reg + LINE_COUNT_WIDTH'(1);
    assign line_cnt_ext    = 32'(line_cnt_reg);

    // Byte decode, quote handling and result forming
    always_comb begin
        mode_mid       = mode_reg;
        plain          = 1'b0;
        emit           = 1'b0;
        sep            = 1'b0;
        val            = 8'h00;
        err            = 1'b0;
        res_valid      = 1'b0;
        res_data       = '0;
        res_data.line_number = line_cnt_ext[LINE_NUMBER_W-1:0];
        mode_next      = mode_reg;
        has_bytes_next = has_bytes_reg;
        line_cnt_next  = line_cnt_reg;

        if (cr_last && !has_bytes_reg) begin
            // Line of only a CR: counted, nothing emitted
            line_cnt_next = line_cnt_bumped;
        end else begin
            has_bytes_next = 1'b1;
            if (!cr_last) begin
                case (mode_reg)
                    QM_QUOTED: begin
                        if (b == CH_QUOTE) begin
                            mode_mid = QM_PENDING;
                        end else begin
                            emit = 1'b1;
                            val  = b;
                        end
                    end
                    QM_PENDING: begin
                        if (b == CH_QUOTE) begin
                            // Doubled quote gives one literal quote
                            emit     = 1'b1;
                            val      = CH_QUOTE;
                            mode_mid = QM_QUOTED;
                        end else begin
                            mode_mid = QM_UNQUOTED;
                            plain    = 1'b1;
                        end
                    end
                    default: begin
                        mode_mid = QM_UNQUOTED;
                        plain    = 1'b1;
                    end
                endcase
                if (plain) begin
                    if (b == CH_QUOTE) begin
                        mode_mid = QM_QUOTED;
                    end else if (b == CH_COMMA) begin
                        sep = 1'b1;
                    end else begin
                        emit = 1'b1;
                        val  = b;
                    end
                end
            end
            mode_next = mode_mid;

            if (last) begin
                // Record end; open quotes flag a format error
                err                    = (mode_mid == QM_QUOTED);
                res_valid              = 1'b1;
                res_data.field_byte    = err ? 8'h00 : val;
                res_data.byte_valid    = !err && emit;
                res_data.end_of_field  = !err && sep;
                res_data.end_of_record = 1'b1;
                res_data.format_error  = err;
                mode_next              = QM_UNQUOTED;
                has_bytes_next         = 1'b0;
                line_cnt_next          = line_cnt_bumped;
            end else if (emit || sep) begin
                res_valid             = 1'b1;
                res_data.field_byte   = val;
                res_data.byte_valid   = emit;
                res_data.end_of_field = sep;
            end
        end
    end

    // Parser state, updated once per consumed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= QM_UNQUOTED;
            has_bytes_reg <= 1'b0;
            line_cnt_reg  <= LINE_COUNT_WIDTH'(1);
        end else if (advance) begin
            mode_reg      <= mode_next;
            has_bytes_reg <= has_bytes_next;
            line_cnt_reg  <= line_cnt_next;
        end
    end

endmodule

>>> rtl/core/clfs_out_reg.sv
module clfs_out_reg
    import clfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  clfs_out_t res_data,
    output logic      out_free,
    output logic      m_valid,
    input  logic      m_ready,
    output clfs_out_t m_data
);

    logic      valid_reg;
    logic      valid_next;
    clfs_out_t data_reg;

    // Room when empty or being drained this cycle
    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_data;
        end
    end

endmodule

>>> rtl/core/csv_line_field_splitter.sv
// CSV line field splitter. Takes one byte of a CSV line per transaction, with
// last_of_line marking the final byte, and returns field bytes with quoting
// removed plus end_of_field / end_of_record markers, a format_error flag for a
// line that ends inside quotes, and the current line number (saturating). The
// block sustains one input byte per clock while the result side is ready: a
// byte passes an input register and is parsed into an output register, from
// which its result is presented on m_valid. Bytes that yield no result
// (opening or closing quotes, a lone-CR line) are consumed silently. Both
// channels stall only on back-pressure from the result side.
module csv_line_field_splitter
    import clfs_pkg::*;
#(
    parameter int LINE_COUNT_WIDTH = LINE_COUNT_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  clfs_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output clfs_out_t m_data
);

    logic      out_free;
    logic      advance;
    clfs_in_t  in_data;
    logic      res_valid;
    clfs_out_t res_data;

    clfs_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .advance  (advance),
        .in_data  (in_data)
    );

    clfs_parser #(
        .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    clfs_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res_data (res_data),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
